// ----- rtl/rtc_pkg.sv -----
// Shared constants, types and field widths for the roller torque control tick unit.
package rtc_pkg;

	// Moving window length in ticks; it must divide 100 so that the mean velocity is exact.
	localparam int WINDOW     = 25;
	localparam int COUNT_BITS = 10;
	localparam int SLOT_W     = $clog2(WINDOW);
	localparam int SUM_W      = COUNT_BITS + $clog2(WINDOW);
	localparam int VEL_SCALE  = 100 / WINDOW;

	localparam int SLOPE_W = 8;
	localparam int MEAS_W  = 8;
	localparam int IN_W    = COUNT_BITS + SLOPE_W + MEAS_W;
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

	localparam int DUTY_W   = 7;
	localparam int TARGET_W = 8;
	localparam int VEL_W    = 17;
	localparam int ACC_W    = 18;
	localparam int OUT_W    = DUTY_W + TARGET_W + VEL_W + ACC_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	localparam int GAIN_W  = 8;
	localparam int CFG_W   = 8;
	localparam int INTEG_W = 16;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd13;
	localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 16'sd32512;
	localparam logic [TARGET_W-1:0] TARGET_LEVEL = 8'd128;

	typedef enum logic {
		REG_INTEGRAL_GAIN = 1'b0,
		REG_DIRECT_MODE   = 1'b1
	} rtc_reg_t;

	// One tick's window results, handed from the window stage to the drive stage.
	typedef struct packed {
		logic signed [VEL_W-1:0] velocity;
		logic signed [ACC_W-1:0] accel;
		logic [TARGET_W-1:0]     target;
		logic [MEAS_W-1:0]       meas;
	} rtc_win_t;

endpackage

// ----- rtl/rtc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module rtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read-first: a read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/rtc_window.sv -----
// Count and velocity rings, running window sum, velocity, acceleration and target current.
module rtc_window (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [rtc_pkg::COUNT_BITS-1:0] count,
	input  logic [rtc_pkg::SLOPE_W-1:0]         slope,
	input  logic [rtc_pkg::MEAS_W-1:0]          meas,
	output logic                                res_valid,
	output rtc_pkg::rtc_win_t                   res,
	input  logic                                res_pop
);
	import rtc_pkg::*;

	logic                  accept;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     next_slot;
	logic                  full_q;
	logic signed [SUM_W-1:0] sum_q;

	logic                  a_valid_s1;
	logic signed [COUNT_BITS-1:0] count_s1;
	logic [SLOPE_W-1:0]    slope_s1;
	logic [MEAS_W-1:0]     meas_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic                  full_s1;

	logic [COUNT_BITS-1:0] cnt_rd;
	logic [VEL_W-1:0]      vel_rd;

	logic signed [SUM_W-1:0]   new_sum;
	logic signed [VEL_W-1:0]   vel;
	logic signed [ACC_W-1:0]   acc;
	logic signed [SLOPE_W:0]   slope_d;
	logic signed [SLOPE_W:0]   slope_q4;
	logic [TARGET_W-1:0]       target;

	logic                  b_valid_s2;
	rtc_win_t              res_s2;

	// A new tick is taken only when the read stage is empty and the result stage is free.
	assign in_ready = !a_valid_s1 && (!b_valid_s2 || res_pop);
	assign accept   = in_valid && in_ready;

	assign next_slot = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);

	rtc_ram #(.WIDTH(COUNT_BITS), .DEPTH(WINDOW)) u_count_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (slot_q),
		.wdata (count),
		.raddr (slot_q),
		.rdata (cnt_rd)
	);

	rtc_ram #(.WIDTH(VEL_W), .DEPTH(WINDOW)) u_vel_ram (
		.clk   (clk),
		.we    (a_valid_s1),
		.waddr (slot_s1),
		.wdata (vel),
		.raddr (next_slot),
		.rdata (vel_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			full_q     <= 1'b0;
			a_valid_s1 <= 1'b0;
		end else begin
			a_valid_s1 <= accept;
			if (accept) begin
				slot_q <= next_slot;
				if (slot_q == SLOT_W'(WINDOW - 1)) begin
					full_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1 <= count;
			slope_s1 <= slope;
			meas_s1  <= meas;
			slot_s1  <= slot_q;
			full_s1  <= full_q;
		end
	end

	always_comb begin
		// Before the window has filled, the slot being replaced has never been written
		// since reset and counts as zero.
		new_sum = sum_q - (full_s1 ? SUM_W'($signed(cnt_rd)) : '0) + SUM_W'(count_s1);
		vel     = full_s1 ? VEL_W'(new_sum) * VEL_W'(VEL_SCALE) : '0;
		acc     = full_s1 ? ACC_W'(vel) - ACC_W'($signed(vel_rd)) : '0;
		// Slope offset divided by four, truncated towards zero.
		slope_d  = $signed({1'b0, slope_s1}) - $signed((SLOPE_W + 1)'(TARGET_LEVEL));
		slope_q4 = (slope_d + (slope_d[SLOPE_W] ? (SLOPE_W + 1)'(3) : (SLOPE_W + 1)'(0))) >>> 2;
		if (vel == '0) begin
			target = TARGET_LEVEL;
		end else begin
			target = TARGET_W'((SLOPE_W + 1)'(TARGET_LEVEL) + slope_q4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			b_valid_s2 <= 1'b0;
		end else begin
			if (a_valid_s1) begin
				sum_q      <= new_sum;
				b_valid_s2 <= 1'b1;
			end else if (res_pop) begin
				b_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (a_valid_s1) begin
			res_s2.velocity <= vel;
			res_s2.accel    <= acc;
			res_s2.target   <= target;
			res_s2.meas     <= meas_s1;
		end
	end

	assign res_valid = b_valid_s2;
	assign res       = res_s2;

endmodule

// ----- rtl/rtc_drive.sv -----
// Drive integrator, sign-magnitude conversion and the output register.
module rtc_drive (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             res_valid,
	input  rtc_pkg::rtc_win_t                res,
	output logic                             res_pop,
	input  logic [rtc_pkg::GAIN_W-1:0]       gain,
	input  logic                             direct,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rtc_pkg::DUTY_W-1:0]       duty,
	output logic                             fwd,
	output logic                             rev,
	output logic [rtc_pkg::TARGET_W-1:0]     target,
	output logic signed [rtc_pkg::VEL_W-1:0] velocity,
	output logic signed [rtc_pkg::ACC_W-1:0] accel
);
	import rtc_pkg::*;

	localparam int ERR_W  = TARGET_W + 2;
	localparam int PROD_W = ERR_W + GAIN_W + 1;
	localparam int ISUM_W = PROD_W + 1;

	logic signed [INTEG_W-1:0] integ_q;
	logic signed [INTEG_W-1:0] integ_new;
	logic signed [ERR_W-1:0]   err;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ISUM_W-1:0]  isum;
	logic signed [TARGET_W:0]  tgt_off;
	logic [INTEG_W-1:0]        mag;
	logic                      out_valid_q;

	assign res_pop = res_valid && (!out_valid_q || out_ready);

	always_comb begin
		tgt_off = $signed({1'b0, res.target}) - $signed((TARGET_W + 1)'(TARGET_LEVEL));
		err     = $signed({2'b00, res.target}) - $signed({2'b00, res.meas});
		prod    = PROD_W'($signed({1'b0, gain})) * PROD_W'(err);
		isum    = ISUM_W'(integ_q) + ISUM_W'(prod);
		if (direct) begin
			integ_new = {tgt_off[INTEG_W-9:0], 8'b0};
		end else if (isum > ISUM_W'(INTEG_LIMIT)) begin
			integ_new = INTEG_LIMIT;
		end else if (isum < -ISUM_W'(INTEG_LIMIT)) begin
			integ_new = -INTEG_LIMIT;
		end else begin
			integ_new = INTEG_W'(isum);
		end
		mag = integ_new[INTEG_W-1] ? INTEG_W'(-integ_new) : integ_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_pop) begin
				integ_q     <= integ_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_pop) begin
			duty     <= mag[DUTY_W+7:8];
			fwd      <= !integ_new[INTEG_W-1] && (integ_new != '0);
			rev      <= integ_new[INTEG_W-1];
			target   <= res.target;
			velocity <= res.velocity;
			accel    <= res.accel;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/roller_torque_control_tick_unit.sv -----
// Top level of the roller torque control tick unit: ports, configuration registers and stages.
//
// One input transfer per sample tick carries the encoder steps since the previous tick,
// the slope potentiometer reading and the measured motor current. For every input transfer
// exactly one output transfer follows, carrying the motor duty magnitude, the drive
// direction flags, the target current, the windowed mean velocity and the acceleration
// figure (velocity change across the window, that is acceleration times 25).
// An input transfer's result passes through the read stage, the result stage and the output
// register, and the output transfer follows once the receiver is ready.
// A new tick is not taken while the read stage still holds the previous one: the window
// stage reads the count and velocity memories in the cycle after a transfer and writes
// the velocity back there, so the tick rate is set by that memory read-modify-write.
// When the receiver stalls, the finished result is held in the output register and one
// further tick may still be taken and brought up to the stage before it; after that
// s_axis_tready stays low until the output transfer completes.
// Reset clears the write slot, the window-full flag, the running count sum and the drive
// integrator, and sets the gain to 13 and direct mode on. The memories are not cleared:
// until the window has filled, the count being replaced is taken as zero, velocity and
// acceleration read zero, and every slot is written before its contents are used.
// Configuration writes take effect at once and are to be made only while the unit is idle.
module roller_torque_control_tick_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// encoder_count [9:0], slope_setting [17:10], measured_current [25:18], zeros above
	input  logic [rtc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// motor_duty [6:0], target_current [14:7], velocity [31:15], acceleration_x25 [49:32],
	// zeros above
	output logic [rtc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// drive_forward [0], drive_reverse [1]
	output logic [rtc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [rtc_pkg::CFG_W-1:0]           cfg_data
);
	import rtc_pkg::*;

	logic [GAIN_W-1:0]   gain_q;
	logic                direct_q;

	logic                res_valid;
	logic                res_pop;
	rtc_win_t            res;

	logic [DUTY_W-1:0]       duty;
	logic                    fwd;
	logic                    rev;
	logic [TARGET_W-1:0]     target;
	logic signed [VEL_W-1:0] velocity;
	logic signed [ACC_W-1:0] accel;

	// Configuration registers: the integrator gain in units of 1/256 and the direct mode flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			direct_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (rtc_reg_t'(cfg_index))
				REG_INTEGRAL_GAIN: gain_q   <= cfg_data[GAIN_W-1:0];
				REG_DIRECT_MODE:   direct_q <= cfg_data[0];
				default:           gain_q   <= gain_q;
			endcase
		end
	end

	// The window stage owns both ring memories and the running sum.
	rtc_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.count     ($signed(s_axis_tdata[COUNT_BITS-1:0])),
		.slope     (s_axis_tdata[COUNT_BITS+SLOPE_W-1:COUNT_BITS]),
		.meas      (s_axis_tdata[IN_W-1:COUNT_BITS+SLOPE_W]),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (res_pop)
	);

	// The drive stage updates the integrator as a result moves into the output register.
	rtc_drive u_drive (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (res_pop),
		.gain      (gain_q),
		.direct    (direct_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.duty      (duty),
		.fwd       (fwd),
		.rev       (rev),
		.target    (target),
		.velocity  (velocity),
		.accel     (accel)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, accel, velocity, target, duty};
	assign m_axis_tuser = {rev, fwd};

endmodule
